>>> hw/rtl/fmi_pkg.sv
// fmi_pkg: shared types, codes and constants of the fm-index engine
package fmi_pkg;

    localparam int SYMBOLS    = 6;
    localparam int TOP_SYMBOL = 5;
    localparam int ROW_W      = 17;

    localparam int DEF_MAX_ROWS        = 65536;
    localparam int DEF_CHECKPOINT_SPAN = 64;
    localparam logic [15:0] RATE_RESET = 16'd32;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_LOCATE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOSAMPLE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RK_START,
        S_RK_CP,
        S_RK_SCAN,
        S_RK_DONE,
        S_LOC_RD,
        S_LOC_CHK,
        S_LOC_ADD,
        S_FINISH
    } fsm_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [2:0]       symbol;
        logic [ROW_W-1:0] row_start;
        logic [ROW_W-1:0] row_end;
        logic             is_sampled;
        logic [15:0]      sample_value;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] new_start;
        logic [ROW_W-1:0] new_end;
        logic [31:0]      text_position;
        logic [1:0]       status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  symbol;
        logic        flag;
        logic [15:0] value;
    } row_entry_t;

    function automatic logic [2:0] clamp_symbol(input logic [2:0] s);
        return (s > 3'(TOP_SYMBOL)) ? 3'(TOP_SYMBOL) : s;
    endfunction

endpackage

>>> hw/rtl/fmi_ram.sv
// fmi_ram: generic single write port ram with registered read
module fmi_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/fm_index_step_and_locate.sv
// fm_index_step_and_locate: fm-index loader, backward-search step and locate engine
//
// input channel: in_valid / in_stall / in_item; an item is taken when in_valid is
// high and in_stall low. one item is worked at a time; in_stall is high while an
// item is in flight. every item yields exactly one result on out_valid /
// out_stall / out_item, held in an output register until taken.
// an advance takes two rank lookups, for row_start and then for row_end. a rank
// lookup reads the checkpoint of the row's block and then scans the rows from
// the block start up to the row, whose offset inside its checkpoint block is
// at most CHECKPOINT_SPAN - 1. a locate reads each row visited and makes one
// rank lookup per lf step until it meets a sampled row; the scan reads the row
// memory through its single read port, one row a cycle. the user writes sample_rate
// through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
// reset clears totals, counters, sample_rate (to 32) and the handshake; the row
// and checkpoint memories are not cleared. when the receiver stalls, the
// result waits in the output register; a following item is accepted and
// worked, and waits at its end until the register frees.
module fm_index_step_and_locate
    import fmi_pkg::*;
#(
    parameter int MAX_ROWS        = DEF_MAX_ROWS,
    parameter int CHECKPOINT_SPAN = DEF_CHECKPOINT_SPAN
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CW     = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int BLOCKS = (MAX_ROWS + CHECKPOINT_SPAN - 1) / CHECKPOINT_SPAN;
    localparam int BLK_AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int OFF_W  = (CHECKPOINT_SPAN > 1) ? $clog2(CHECKPOINT_SPAN) : 1;

    fsm_t             state_reg, state_next;
    logic [1:0]       act_reg, act_next;
    logic [2:0]       sym_reg, sym_next;
    logic             phase_reg, phase_next;
    logic [CW-1:0]    b_reg, b_next;
    logic [CW-1:0]    rk_pos_reg, rk_pos_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    loc_pos_reg, loc_pos_next;
    logic [15:0]      steps_reg, steps_next;
    logic [31:0]      prod_reg, prod_next;
    out_item_t        res_reg, res_next;
    out_item_t        out_item_reg, out_item_next;
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    totals_reg [SYMBOLS];
    logic [CW-1:0]    totals_next [SYMBOLS];
    logic [CW-1:0]    rows_reg, rows_next;
    logic [CW-1:0]    samples_reg, samples_next;
    logic [OFF_W-1:0] load_off_reg, load_off_next;
    logic [BLK_AW-1:0] load_blk_reg, load_blk_next;
    logic [15:0]      rate_reg;

    logic             row_wr_en;
    logic [ROW_AW-1:0] row_rd_addr;
    row_entry_t       row_wr_data, row_rd_data;
    logic             cp_wr_en;
    logic [BLK_AW-1:0] cp_rd_addr;
    logic [SYMBOLS*CW-1:0] cp_wr_data, cp_rd_data;

    logic [2:0]       in_sym;
    logic [CW-1:0]    a_ext, b_ext;
    logic [15:0]      rate_eff;
    logic [CW-1:0]    start_off;
    logic [CW-1:0]    lf;
    logic [CW-1:0]    cnt_inc;
    logic             full;

    fmi_ram #(.WIDTH($bits(row_entry_t)), .DEPTH(MAX_ROWS)) u_row_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (rows_reg[ROW_AW-1:0]),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    fmi_ram #(.WIDTH(SYMBOLS*CW), .DEPTH(BLOCKS)) u_cp_ram (
        .clk     (clk),
        .wr_en   (cp_wr_en),
        .wr_addr (load_blk_reg),
        .wr_data (cp_wr_data),
        .rd_addr (cp_rd_addr),
        .rd_data (cp_rd_data)
    );

    assign in_sym   = clamp_symbol(in_item.symbol);
    assign a_ext    = CW'(in_item.row_start);
    assign b_ext    = CW'(in_item.row_end);
    assign rate_eff = (rate_reg == 16'd0) ? 16'd1 : rate_reg;
    assign full     = (rows_reg >= CW'(MAX_ROWS));
    assign cnt_inc  = cnt_reg + CW'(row_rd_data.symbol == sym_reg);
    assign lf       = start_off + cnt_reg;

    assign row_wr_data.symbol = in_sym;
    assign row_wr_data.flag   = in_item.is_sampled;
    assign row_wr_data.value  = in_item.sample_value;

    always_comb
    begin
        for (int s = 0; s < SYMBOLS; s++)
        begin
            cp_wr_data[s*CW +: CW] = totals_reg[s];
        end
    end

    // start offset of the step symbol: totals of all smaller symbols
    always_comb
    begin
        start_off = '0;
        for (int s = 0; s < SYMBOLS; s++)
        begin
            if (3'(s) < sym_reg)
            begin
                start_off = start_off + totals_reg[s];
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            rate_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rows_reg      <= '0;
            samples_reg   <= '0;
            load_off_reg  <= '0;
            load_blk_reg  <= '0;
            for (int s = 0; s < SYMBOLS; s++)
            begin
                totals_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rows_reg      <= rows_next;
            samples_reg   <= samples_next;
            load_off_reg  <= load_off_next;
            load_blk_reg  <= load_blk_next;
            for (int s = 0; s < SYMBOLS; s++)
            begin
                totals_reg[s] <= totals_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        sym_reg      <= sym_next;
        phase_reg    <= phase_next;
        b_reg        <= b_next;
        rk_pos_reg   <= rk_pos_next;
        scan_reg     <= scan_next;
        cnt_reg      <= cnt_next;
        loc_pos_reg  <= loc_pos_next;
        steps_reg    <= steps_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        sym_next       = sym_reg;
        phase_next     = phase_reg;
        b_next         = b_reg;
        rk_pos_next    = rk_pos_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        loc_pos_next   = loc_pos_reg;
        steps_next     = steps_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        rows_next      = rows_reg;
        samples_next   = samples_reg;
        load_off_next  = load_off_reg;
        load_blk_next  = load_blk_reg;
        for (int s = 0; s < SYMBOLS; s++)
        begin
            totals_next[s] = totals_reg[s];
        end
        row_wr_en   = 1'b0;
        cp_wr_en    = 1'b0;
        row_rd_addr = scan_reg[ROW_AW-1:0];
        cp_rd_addr  = BLK_AW'(rk_pos_reg / CHECKPOINT_SPAN);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = in_item.action;
                    res_next = '0;
                    case (in_item.action)
                        ACT_CLEAR:
                        begin
                            for (int s = 0; s < SYMBOLS; s++)
                            begin
                                totals_next[s] = '0;
                            end
                            rows_next     = '0;
                            samples_next  = '0;
                            load_off_next = '0;
                            load_blk_next = '0;
                            state_next    = S_FINISH;
                        end
                        ACT_LOAD:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                row_wr_en = 1'b1;
                                cp_wr_en  = (load_off_reg == '0);
                                totals_next[in_sym] = totals_reg[in_sym] + CW'(1);
                                samples_next = samples_reg + CW'(in_item.is_sampled);
                                rows_next    = rows_reg + CW'(1);
                                if (load_off_reg == OFF_W'(CHECKPOINT_SPAN - 1))
                                begin
                                    load_off_next = '0;
                                    load_blk_next = load_blk_reg + BLK_AW'(1);
                                end
                                else
                                begin
                                    load_off_next = load_off_reg + OFF_W'(1);
                                end
                            end
                            state_next = S_FINISH;
                        end
                        ACT_ADVANCE:
                        begin
                            if (a_ext > rows_reg || b_ext > rows_reg)
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                rk_pos_next = a_ext;
                                b_next      = b_ext;
                                sym_next    = in_sym;
                                phase_next  = 1'b0;
                                state_next  = S_RK_START;
                            end
                        end
                        default:
                        begin
                            if (a_ext >= rows_reg)
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                loc_pos_next = a_ext;
                                steps_next   = '0;
                                state_next   = S_LOC_RD;
                            end
                        end
                    endcase
                end
            end
            S_RK_START:
            begin
                if (rk_pos_reg >= rows_reg)
                begin
                    cnt_next   = totals_reg[sym_reg];
                    state_next = S_RK_DONE;
                end
                else
                begin
                    scan_next  = CW'(rk_pos_reg / CHECKPOINT_SPAN) * CW'(CHECKPOINT_SPAN);
                    state_next = S_RK_CP;
                end
            end
            S_RK_CP:
            begin
                cnt_next = cp_rd_data[sym_reg*CW +: CW];
                if (scan_reg == rk_pos_reg)
                begin
                    state_next = S_RK_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_RK_SCAN;
                end
            end
            S_RK_SCAN:
            begin
                // row data here belongs to the row addressed in the previous cycle
                cnt_next = cnt_inc;
                if (scan_reg == rk_pos_reg)
                begin
                    state_next = S_RK_DONE;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_RK_DONE:
            begin
                if (act_reg == ACT_ADVANCE)
                begin
                    if (!phase_reg)
                    begin
                        res_next.new_start = lf[ROW_W-1:0];
                        rk_pos_next        = b_reg;
                        phase_next         = 1'b1;
                        state_next         = S_RK_START;
                    end
                    else
                    begin
                        res_next.new_end = lf[ROW_W-1:0];
                        state_next       = S_FINISH;
                    end
                end
                else if (lf >= rows_reg)
                begin
                    res_next.status = ST_NOSAMPLE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    loc_pos_next = lf;
                    steps_next   = steps_reg + 16'd1;
                    state_next   = S_LOC_RD;
                end
            end
            S_LOC_RD:
            begin
                row_rd_addr = loc_pos_reg[ROW_AW-1:0];
                state_next  = S_LOC_CHK;
            end
            S_LOC_CHK:
            begin
                if (row_rd_data.flag)
                begin
                    prod_next  = 32'(row_rd_data.value) * 32'(rate_eff);
                    state_next = S_LOC_ADD;
                end
                else if ((17'(steps_reg) + 17'd1) >= 17'(rate_eff))
                begin
                    res_next.status = ST_NOSAMPLE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rk_pos_next = loc_pos_reg;
                    sym_next    = row_rd_data.symbol;
                    state_next  = S_RK_START;
                end
            end
            S_LOC_ADD:
            begin
                res_next.text_position = prod_reg + 32'(steps_reg);
                state_next             = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg <= CW'(MAX_ROWS))
        else $error("row count beyond capacity");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.action == ACT_LOAD && !full)
        |=> rows_reg == $past(rows_reg) + CW'(1))
        else $error("load item did not bump the row count");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RK_SCAN) |-> (scan_reg <= rk_pos_reg))
        else $error("rank scan ran past its row");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && out_stall) |=> state_reg == S_FINISH)
        else $error("result overwrote a stalled output item");

endmodule

>>> verif/fmi_checker.sv
// fmi_checker: watches the item channels, predicts each result and compares
module fmi_checker
    import fmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_item,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    localparam int MAXR = DEF_MAX_ROWS;

    logic [2:0]       row_sym  [MAXR];
    logic             row_flag [MAXR];
    logic [15:0]      row_val  [MAXR];
    // symbol counts in the rows before each row index
    logic [ROW_W-1:0] prefix_cnt [MAXR+1][SYMBOLS];
    int               rows_in;
    logic [15:0]      rate_reg;
    out_item_t        expected_q[$];

    function automatic logic [ROW_W-1:0] rank_before(int pos, int c);
        return (pos >= rows_in) ? prefix_cnt[rows_in][c] : prefix_cnt[pos][c];
    endfunction

    function automatic logic [ROW_W-1:0] lf_step(int pos, int c);
        logic [ROW_W-1:0] sum;
        sum = '0;
        for (int s = 0; s < c; s++)
            sum += prefix_cnt[rows_in][s];
        return sum + rank_before(pos, c);
    endfunction

    function automatic out_item_t fm_predict(in_item_t it);
        out_item_t r;
        int sym;
        int pos;
        int steps;
        int rate;
        bit fail;
        r = '0;
        r.status = ST_OK;
        sym = (it.symbol > 3'(TOP_SYMBOL)) ? TOP_SYMBOL : int'(it.symbol);
        case (action_t'(it.action))
            ACT_CLEAR: rows_in = 0;
            ACT_LOAD:
                if (rows_in >= MAXR)
                    r.status = ST_FULL;
                else
                begin
                    row_sym[rows_in]  = 3'(sym);
                    row_flag[rows_in] = it.is_sampled;
                    row_val[rows_in]  = it.sample_value;
                    for (int s = 0; s < SYMBOLS; s++)
                        prefix_cnt[rows_in+1][s] = prefix_cnt[rows_in][s] + (s == sym);
                    rows_in++;
                end
            ACT_ADVANCE:
                if (it.row_start > rows_in || it.row_end > rows_in)
                    r.status = ST_RANGE;
                else
                begin
                    r.new_start = lf_step(int'(it.row_start), sym);
                    r.new_end   = lf_step(int'(it.row_end), sym);
                end
            default:
                if (it.row_start >= rows_in)
                    r.status = ST_RANGE;
                else
                begin
                    rate  = (rate_reg == 0) ? 1 : int'(rate_reg);
                    pos   = int'(it.row_start);
                    steps = 0;
                    fail  = 0;
                    while (!row_flag[pos])
                    begin
                        if (steps + 1 >= rate)
                        begin
                            fail = 1;
                            break;
                        end
                        pos = int'(lf_step(pos, int'(row_sym[pos])));
                        if (pos >= rows_in)
                        begin
                            fail = 1;
                            break;
                        end
                        steps++;
                    end
                    if (fail)
                        r.status = ST_NOSAMPLE;
                    else
                        r.text_position = 32'(row_val[pos] * rate + steps);
                end
        endcase
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            rows_in      = 0;
            rate_reg     = RATE_RESET;
            errors       = 0;
            results_seen = 0;
            for (int s = 0; s < SYMBOLS; s++)
                prefix_cnt[0][s] = '0;
            expected_q.delete();
        end
        else
        begin
            // retire before predicting so a same-edge accept never matches itself
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", out_item);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.new_start !== want.new_start
                        || out_item.new_end !== want.new_end
                        || out_item.text_position !== want.text_position
                        || out_item.status !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", want, out_item);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q = {expected_q, fm_predict(in_item)};
            if (cfg_wr_en)
                rate_reg = cfg_wr_data;
        end
    end

endmodule

>>> verif/testbench.sv
// testbench: stimulus, handshake pacing and verdict for the fm-index engine
module testbench;
    import fmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          errors;
    int          pending;
    int          results_seen;

    int tx_idle_pct;
    int rx_idle_pct;
    int rows_now;
    int items_sent;
    int idle_cycles = 0;
    bit hold_req;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    fm_index_step_and_locate dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    fmi_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver pacing with a single long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic in_item_t make_item(action_t act, int sym, int rs, int re,
                                           bit smp, int val);
        in_item_t it;
        it.action       = act;
        it.symbol       = 3'(sym);
        it.row_start    = ROW_W'(rs);
        it.row_end      = ROW_W'(re);
        it.is_sampled   = smp;
        it.sample_value = 16'(val);
        return it;
    endfunction

    task automatic send(in_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        case (action_t'(it.action))
            ACT_CLEAR: rows_now = 0;
            ACT_LOAD:  if (rows_now < DEF_MAX_ROWS) rows_now++;
            default:   ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_rate(int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 16'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic load_random(int count, int samp_pct);
        for (int i = 0; i < count; i++)
            send(make_item(ACT_LOAD, $urandom_range(7), $urandom_range(131071),
                           $urandom_range(131071), $urandom_range(99) < samp_pct,
                           $urandom));
    endtask

    // one index built from scratch, then mostly in-range queries, some extra loads and some noise
    task automatic query_set(int nrows, int queries, int samp_pct);
        int pick;
        int rs;
        int re;
        in_item_t it;
        send(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
        load_random(nrows, samp_pct);
        for (int q = 0; q < queries; q++)
        begin
            pick = $urandom_range(99);
            rs = $urandom_range(rows_now);
            re = $urandom_range(rows_now);
            if ($urandom_range(9) == 0)
                re = ($urandom_range(1)) ? rows_now + 1 : $urandom_range(131071);
            if (pick < 45)
                send(make_item(ACT_ADVANCE, $urandom_range(7), rs, re, 0, 0));
            else if (pick < 88)
                send(make_item(ACT_LOCATE, 0, (rs == rows_now) ? 0 : rs, 0, 0, 0));
            else if (pick < 94)
                load_random(1, samp_pct);
            else
            begin
                it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
                if (it.action == ACT_CLEAR)
                    it.action = ACT_ADVANCE;
                send(it);
            end
        end
    endtask

    initial
    begin
        int rates[7];
        rates = '{1, 0, 3, 5, 8, 16, 4};
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        hold_req    = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rows_now    = 0;
        items_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty index, saturated symbols, edge rows, reset sample rate
        send(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
        send(make_item(ACT_ADVANCE, 7, 0, 0, 0, 0));
        send(make_item(ACT_LOCATE, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOAD, 2, 0, 0, 1, 16'hFFFF));
        send(make_item(ACT_LOAD, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOAD, 6, 0, 0, 1, 0));
        send(make_item(ACT_LOAD, 7, 0, 0, 0, 16'h5A5A));
        send(make_item(ACT_LOAD, 1, 0, 0, 0, 0));
        send(make_item(ACT_LOAD, 3, 0, 0, 1, 16'h1234));
        send(make_item(ACT_LOAD, 4, 0, 0, 0, 0));
        send(make_item(ACT_ADVANCE, 0, 0, 7, 0, 0));
        send(make_item(ACT_ADVANCE, 5, 7, 7, 0, 0));
        send(make_item(ACT_ADVANCE, 6, 3, 5, 0, 0));
        send(make_item(ACT_ADVANCE, 2, 0, 8, 0, 0));
        send(make_item(ACT_ADVANCE, 1, 17'h1FFFF, 2, 0, 0));
        for (int r = 0; r < 7; r++)
            send(make_item(ACT_LOCATE, 0, r, 0, 0, 0));
        send(make_item(ACT_LOCATE, 0, 7, 0, 0, 0));
        send(make_item(ACT_LOCATE, 0, 17'h1FFFF, 0, 0, 0));

        // random phases under three pacing patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 66 : 0;
            rx_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 34 : 0;
            for (int s = 0; s < 4; s++)
            begin
                set_rate(rates[(mode * 4 + s) % 7]);
                if (mode == 0 && s == 1)
                    hold_req = ~hold_req;
                query_set($urandom_range(1, 30), 25, $urandom_range(5, 60));
            end
        end

        // largest sample rate: all rows sampled but one terminator row that maps to row 0
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_rate(16'hFFFF);
        send(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
        send(make_item(ACT_LOAD, 3, 0, 0, 1, 16'hFFFF));
        for (int i = 1; i < 40; i++)
            send(make_item(ACT_LOAD, (i == 9) ? 0 : $urandom_range(1, 7), 0, 0,
                           i != 9, $urandom));
        send(make_item(ACT_LOCATE, 0, 9, 0, 0, 0));
        for (int q = 0; q < 10; q++)
            send(make_item(ACT_LOCATE, 0, $urandom_range(39), 0, 0, 0));

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d items, %0d results: clear, load, advance, locate,", items_sent,
                 results_seen);
        $display("range and no-sample errors, sample rates 0 to 65535");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
